[design/rbr_pkg.sv]
// Shared types and constants for the reflectance barcode reader.
// No dependencies; imported by every module of the block.
package rbr_pkg;

    localparam int SAMPLE_W       = 10;
    localparam int LEVEL_W        = 10;
    localparam int MIN_W          = 11;
    localparam int EVENT_W        = 3;
    localparam int POS_W          = 2;
    localparam int CFG_INDEX_W    = 2;
    localparam int DIGITS_DEFAULT = 4;

    localparam logic [MIN_W-1:0] NO_MIN          = 11'd1500;
    localparam logic [MIN_W-1:0] MIN_VALID_LIMIT = 11'd1000;

    localparam logic [LEVEL_W-1:0] BLACK_RESET = 10'd10;
    localparam logic [LEVEL_W-1:0] WHITE_RESET = 10'd38;
    localparam logic [LEVEL_W-1:0] TILE_RESET  = 10'd25;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_BLACK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WHITE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_START = 3'b010,
        PH_DIGIT = 3'b100
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 3'd0,
        EV_START = 3'd1,
        EV_TILE  = 3'd2,
        EV_ZERO  = 3'd3,
        EV_ONE   = 3'd4,
        EV_UNCL  = 3'd5
    } event_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] black_level;
        logic [LEVEL_W-1:0] white_level;
        logic [LEVEL_W-1:0] tile_level;
    } cfg_t;

    typedef struct packed {
        event_t           event_res;
        logic [POS_W-1:0] digit_position;
        logic             code_done;
    } result_t;

endpackage

[design/rbr_cfg.sv]
// Configuration register file for the reflectance barcode reader.
// Depends on rbr_pkg for the register indexes and the cfg_t struct.
module rbr_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [rbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rbr_pkg::LEVEL_W-1:0]      cfg_data,
    output logic                             cfg_ready,
    output rbr_pkg::cfg_t                    cfg
);
    import rbr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BLACK: cfg_next.black_level = cfg_data;
                REG_WHITE: cfg_next.white_level = cfg_data;
                REG_TILE:  cfg_next.tile_level  = cfg_data;
                default:   cfg_next = cfg_reg;   // drop writes beyond the list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.black_level <= BLACK_RESET;
            cfg_reg.white_level <= WHITE_RESET;
            cfg_reg.tile_level  <= TILE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/rbr_step.sv]
// Next-state and event logic for one sample of the barcode reader.
// Purely combinational; depends on rbr_pkg for phase, event and struct types.
module rbr_step #(
    parameter int DIGITS  = rbr_pkg::DIGITS_DEFAULT,
    parameter int DIGIT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
    input  logic [rbr_pkg::SAMPLE_W-1:0] sample,
    input  rbr_pkg::cfg_t                cfg,
    input  rbr_pkg::phase_t              phase,
    input  logic [DIGIT_W-1:0]           digit_cnt,
    input  logic [rbr_pkg::MIN_W-1:0]    bar_minimum,
    input  logic [rbr_pkg::LEVEL_W-1:0]  bar_maximum,
    output rbr_pkg::phase_t              phase_next,
    output logic [DIGIT_W-1:0]           digit_cnt_next,
    output logic [rbr_pkg::MIN_W-1:0]    bar_minimum_next,
    output logic [rbr_pkg::LEVEL_W-1:0]  bar_maximum_next,
    output rbr_pkg::result_t             result
);
    import rbr_pkg::*;

    localparam logic [DIGIT_W-1:0] LAST_DIGIT = DIGIT_W'(DIGITS - 1);

    logic [LEVEL_W-1:0]   peak;
    logic [MIN_W-1:0]     sample_ext;
    logic [MIN_W-1:0]     white_ext;
    logic [DIGIT_W+1:0]   pos_ext;

    assign peak       = (sample > bar_maximum) ? sample : bar_maximum;
    assign sample_ext = {1'b0, sample};
    assign white_ext  = {1'b0, cfg.white_level};
    assign pos_ext    = {2'b00, digit_cnt};

    always_comb
    begin
        phase_next       = phase;
        digit_cnt_next   = digit_cnt;
        bar_minimum_next = bar_minimum;
        bar_maximum_next = bar_maximum;
        result.event_res      = EV_NONE;
        result.digit_position = '0;
        result.code_done      = 1'b0;

        unique case (phase)
            PH_IDLE:
            begin
                if (sample <= cfg.black_level)
                begin
                    phase_next = PH_START;
                end
            end
            PH_START:
            begin
                bar_maximum_next = peak;
                if (peak >= cfg.white_level)
                begin
                    result.event_res = EV_START;
                    phase_next       = PH_DIGIT;
                    digit_cnt_next   = '0;
                    bar_maximum_next = '0;
                end
                else if (sample <= cfg.black_level && peak >= cfg.tile_level)
                begin
                    result.event_res = EV_TILE;
                    phase_next       = PH_IDLE;
                    bar_maximum_next = '0;
                    bar_minimum_next = NO_MIN;
                end
            end
            PH_DIGIT:
            begin
                bar_maximum_next = '0;
                if (sample > cfg.white_level && bar_minimum >= MIN_VALID_LIMIT)
                begin
                    // white before any bar sample: re-arm the minimum
                    bar_minimum_next = NO_MIN;
                end
                else if (sample_ext < bar_minimum)
                begin
                    bar_minimum_next = sample_ext;
                end
                else if (sample >= cfg.white_level)
                begin
                    if (bar_minimum <= {1'b0, cfg.black_level})
                    begin
                        result.event_res = EV_ZERO;
                    end
                    else if (bar_minimum < white_ext)
                    begin
                        result.event_res = EV_ONE;
                    end
                    else
                    begin
                        result.event_res = EV_UNCL;
                    end
                    result.digit_position = pos_ext[POS_W-1:0];
                    bar_minimum_next      = NO_MIN;
                    if (digit_cnt == LAST_DIGIT)
                    begin
                        result.code_done = 1'b1;
                        phase_next       = PH_IDLE;
                        digit_cnt_next   = '0;
                    end
                    else
                    begin
                        digit_cnt_next = digit_cnt + DIGIT_W'(1);
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

endmodule

[design/reflectance_barcode_reader.sv]
// Reflectance barcode reader: input sample register, one step of phase logic,
// result register. Throughput one sample per cycle while result_stall is low;
// the phase state updates as a sample moves from the input register into the
// result register.
// Reset (rst_n, async low) empties both registers, puts the phase at idle,
// the bar minimum at its no-minimum mark and the levels at 10/38/25.
module reflectance_barcode_reader #(
    parameter int DIGITS = rbr_pkg::DIGITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // sample channel
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  logic [rbr_pkg::SAMPLE_W-1:0]     sample,
    // result channel
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [rbr_pkg::EVENT_W-1:0]      event_res,
    output logic [rbr_pkg::POS_W-1:0]        digit_position,
    output logic                             code_done,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rbr_pkg::LEVEL_W-1:0]      cfg_data
);
    import rbr_pkg::*;

    localparam int DIGIT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    cfg_t cfg;

    // Input register
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [SAMPLE_W-1:0] s1_sample_reg;

    // Phase state, advanced once per sample that leaves the input register
    phase_t              phase_reg;
    phase_t              phase_next;
    logic [DIGIT_W-1:0]  digit_cnt_reg;
    logic [DIGIT_W-1:0]  digit_cnt_next;
    logic [MIN_W-1:0]    bar_minimum_reg;
    logic [MIN_W-1:0]    bar_minimum_next;
    logic [LEVEL_W-1:0]  bar_maximum_reg;
    logic [LEVEL_W-1:0]  bar_maximum_next;

    // Result register
    logic                result_valid_reg;
    logic                result_valid_next;
    result_t             result_reg;
    result_t             step_result;

    logic                out_free;
    logic                s1_fire;
    logic                sample_accept;

    rbr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    rbr_step #(
        .DIGITS  (DIGITS),
        .DIGIT_W (DIGIT_W)
    ) u_step (
        .sample           (s1_sample_reg),
        .cfg              (cfg),
        .phase            (phase_reg),
        .digit_cnt        (digit_cnt_reg),
        .bar_minimum      (bar_minimum_reg),
        .bar_maximum      (bar_maximum_reg),
        .phase_next       (phase_next),
        .digit_cnt_next   (digit_cnt_next),
        .bar_minimum_next (bar_minimum_next),
        .bar_maximum_next (bar_maximum_next),
        .result           (step_result)
    );

    // The result register can take a new value when empty or being drained.
    assign out_free      = !result_valid_reg || !result_stall;
    assign s1_fire       = s1_valid_reg && out_free;
    assign sample_stall  = s1_valid_reg && !out_free;
    assign sample_accept = sample_valid && !sample_stall;

    always_comb
    begin
        if (sample_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            phase_reg        <= PH_IDLE;
            digit_cnt_reg    <= '0;
            bar_minimum_reg  <= NO_MIN;
            bar_maximum_reg  <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            // advance the phase state only when a transaction moves to the output
            if (s1_fire)
            begin
                phase_reg       <= phase_next;
                digit_cnt_reg   <= digit_cnt_next;
                bar_minimum_reg <= bar_minimum_next;
                bar_maximum_reg <= bar_maximum_next;
            end
        end
    end

    // Payload registers: hold while stalled, load on each move
    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            s1_sample_reg <= sample;
        end
        if (s1_fire)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid   = result_valid_reg;
    assign event_res      = result_reg.event_res;
    assign digit_position = result_reg.digit_position;
    assign code_done      = result_reg.code_done;

    // Outside the digit phases no bar minimum is ever held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_DIGIT) |-> (bar_minimum_reg == NO_MIN))
        else $error("bar minimum held outside digit phase");

    // The running peak only lives in the start bar.
    assert property (@(posedge clk) disable iff (!rst_n)
        (bar_maximum_reg != '0) |-> (phase_reg == PH_START))
        else $error("bar maximum nonzero outside start bar");

    // The digit counter rests at zero when no code is being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_DIGIT) |-> (digit_cnt_reg == '0))
        else $error("digit counter not cleared outside digits");

    // Code completion comes only with a digit event and returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && step_result.code_done) |->
            ((step_result.event_res == EV_ZERO || step_result.event_res == EV_ONE
              || step_result.event_res == EV_UNCL) && phase_next == PH_IDLE))
        else $error("code done without a final digit");

    // The state moves only when a transaction leaves the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(s1_fire) |-> ($stable(phase_reg) && $stable(bar_minimum_reg)))
        else $error("phase state changed without a transaction");

endmodule

[tb/sv/tb_reflectance_barcode_reader.sv]
// Self-checking testbench for the reflectance barcode reader: directed and random
// sample streams under several level settings and idling mixes.
// Depends on rbr_pkg and the reflectance_barcode_reader top level.
module tb_reflectance_barcode_reader;
    timeunit 1ns;
    timeprecision 1ps;

    import rbr_pkg::*;

    localparam int DIGITS = DIGITS_DEFAULT;
    // Index past the register list: the block must ignore writes to it
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    // Cycles without any accepted transaction before the run is abandoned
    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int RANDOM_PHASES = 9;

    // Scoreboard: tracks the reader's phase machine on accepted samples and
    // holds the events it must report, oldest first.
    class barcode_scoreboard;
        logic [LEVEL_W-1:0] black_level = BLACK_RESET;
        logic [LEVEL_W-1:0] white_level = WHITE_RESET;
        logic [LEVEL_W-1:0] tile_level  = TILE_RESET;
        phase_t             phase       = PH_IDLE;
        int                 digit_index = 0;
        logic [MIN_W-1:0]   bar_min     = NO_MIN;
        logic [SAMPLE_W-1:0] bar_max    = '0;
        result_t            pending[$];
        int                 mismatch_count = 0;

        function void write_level(logic [CFG_INDEX_W-1:0] idx, logic [LEVEL_W-1:0] data);
            case (idx)
                REG_BLACK: black_level = data;
                REG_WHITE: white_level = data;
                REG_TILE:  tile_level  = data;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            result_t r;
            r.event_res      = EV_NONE;
            r.digit_position = '0;
            r.code_done      = 1'b0;
            case (phase)
                PH_IDLE: begin
                    if (s <= black_level)
                        phase = PH_START;
                end
                PH_START: begin
                    if (s > bar_max)
                        bar_max = s;
                    if (bar_max >= white_level) begin
                        r.event_res = EV_START;
                        phase       = PH_DIGIT;
                        digit_index = 0;
                        bar_max     = '0;
                    end else if (s <= black_level && bar_max >= tile_level) begin
                        r.event_res = EV_TILE;
                        phase       = PH_IDLE;
                        bar_max     = '0;
                        bar_min     = NO_MIN;
                    end
                end
                default: begin
                    if (s > white_level && bar_min >= MIN_VALID_LIMIT) begin
                        bar_min = NO_MIN;
                    end else if ({1'b0, s} < bar_min) begin
                        bar_min = {1'b0, s};
                    end else if (s >= white_level) begin
                        if (bar_min <= {1'b0, black_level})
                            r.event_res = EV_ZERO;
                        else if (bar_min < {1'b0, white_level})
                            r.event_res = EV_ONE;
                        else
                            r.event_res = EV_UNCL;
                        r.digit_position = digit_index[POS_W-1:0];
                        digit_index      = digit_index + 1;
                        bar_min          = NO_MIN;
                        if (digit_index >= DIGITS) begin
                            r.code_done = 1'b1;
                            phase       = PH_IDLE;
                        end
                    end
                    bar_max = '0;
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(logic [EVENT_W-1:0] ev, logic [POS_W-1:0] pos,
                                   logic done);
            result_t want;
            if (pending.size() == 0) begin
                $error("result with no event pending: event_res %0d digit_position %0d code_done %0d",
                       ev, pos, done);
                mismatch_count++;
                return;
            end
            want = pending.pop_front();
            if (ev !== want.event_res) begin
                $error("event_res expected %0d actual %0d", want.event_res, ev);
                mismatch_count++;
            end
            if (pos !== want.digit_position) begin
                $error("digit_position expected %0d actual %0d", want.digit_position, pos);
                mismatch_count++;
            end
            if (done !== want.code_done) begin
                $error("code_done expected %0d actual %0d", want.code_done, done);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    logic [SAMPLE_W-1:0]    sample = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [EVENT_W-1:0]     event_res;
    logic [POS_W-1:0]       digit_position;
    logic                   code_done;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [LEVEL_W-1:0]     cfg_data = '0;

    barcode_scoreboard sb = new();

    // Percent chance per cycle that the sender holds off or the receiver stalls
    int send_idle_pct = 13;
    int recv_idle_pct = 76;
    int quiet_cycles  = 0;

    // Levels currently programmed, used to shape the random sample streams
    int lvl_black = BLACK_RESET;
    int lvl_white = WHITE_RESET;
    int lvl_tile  = TILE_RESET;

    logic [SAMPLE_W-1:0] stim_q[$];

    reflectance_barcode_reader #(
        .DIGITS(DIGITS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .event_res      (event_res),
        .digit_position (digit_position),
        .code_done      (code_done),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    // Result side: randomize the stall for the next cycle and check every
    // transaction accepted at this edge. Values read here are the pre-edge ones.
    always @(posedge clk) begin
        result_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        if (result_valid && !result_stall)
            sb.check_result(event_res, digit_position, code_done);
    end

    // Watchdog: count cycles in which no channel moves a transaction.
    always @(posedge clk) begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Random value in [lo, hi] clipped to the sample range; any value when empty
    function automatic logic [SAMPLE_W-1:0] pick(int lo, int hi);
        if (lo < 0)
            lo = 0;
        if (hi > 1023)
            hi = 1023;
        if (lo > hi)
            return SAMPLE_W'($urandom_range(1023, 0));
        return SAMPLE_W'($urandom_range(hi, lo));
    endfunction

    // Push every queued sample through the sample channel, with random gaps
    // between transactions. Valid is only dropped between items, never while
    // one is waiting on stall.
    task automatic send_samples();
        logic [SAMPLE_W-1:0] s;
        while (stim_q.size() != 0) begin
            s = stim_q.pop_front();
            while ($urandom_range(99, 0) < send_idle_pct) begin
                sample_valid <= 1'b0;
                @(posedge clk);
            end
            sample_valid <= 1'b1;
            sample       <= s;
            do @(posedge clk); while (sample_stall);
            sb.note_sample(s);
        end
        sample_valid <= 1'b0;
    endtask

    // Hold until every predicted event has come back
    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Program all three levels plus the unused index, back to back; valid stays
    // high across the writes and drops once at the end.
    task automatic apply_levels(int b, int w, int t);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [LEVEL_W-1:0]     val [4];
        idx = '{REG_BLACK, REG_WHITE, REG_TILE, REG_UNUSED};
        val = '{LEVEL_W'(b), LEVEL_W'(w), LEVEL_W'(t), LEVEL_W'($urandom_range(1023, 0))};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            sb.write_level(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        lvl_black = b;
        lvl_white = w;
        lvl_tile  = t;
    endtask

    // Queue one well-formed scan: leading background, start bar, then either a
    // floor-tile abort or a full code with one bar per digit.
    task automatic append_code();
        int kind;
        repeat ($urandom_range(2, 0))
            stim_q.push_back(pick(lvl_black + 1, 1023));
        stim_q.push_back(pick(0, lvl_black));
        if ($urandom_range(4, 0) == 0) begin
            // Floor tile: peak at tile level without reaching white, then black
            stim_q.push_back(pick(lvl_tile, lvl_white - 1));
            stim_q.push_back(pick(0, lvl_black));
            return;
        end
        repeat ($urandom_range(3, 0))
            stim_q.push_back(pick(lvl_black + 1, lvl_tile - 1));
        stim_q.push_back(pick(lvl_white, 1023));
        for (int d = 0; d < DIGITS; d++) begin
            // Background above white before the bar leaves the minimum unset
            if ($urandom_range(3, 0) == 0)
                stim_q.push_back(pick(lvl_white + 1, 1023));
            kind = $urandom_range(2, 0);
            case (kind)
                0:       stim_q.push_back(pick(0, lvl_black));
                1:       stim_q.push_back(pick(lvl_black + 1, lvl_white - 1));
                default: stim_q.push_back(pick(lvl_white, lvl_white));
            endcase
            repeat ($urandom_range(2, 0))
                stim_q.push_back(pick(0, lvl_white - 1));
            stim_q.push_back(pick(lvl_white, 1023));
        end
    endtask

    initial begin
        int b;
        int w;
        int t;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at the reset levels (black 10, white 38, tile 25)
        stim_q = '{
            10'd1023, 10'd11,                 // idle: not black
            10'd10,                           // black at the level opens the start bar
            10'd15, 10'd37,                   // start bar: no start, no abort
            10'd38,                           // peak reaches white: code start
            10'd39, 10'd0, 10'd38,            // white with no minimum, then digit zero
            10'd20, 10'd37, 10'd1023,         // grey bar: digit one
            10'd38, 10'd38,                   // white-level minimum: unclassified
            10'd10, 10'd1023,                 // last digit zero, code done
            10'd0, 10'd30, 10'd10,            // tile peak then black: abort
            10'd1023, 10'd5, 10'd1023,        // fresh code start
            10'd11, 10'd38                    // one more digit
        };
        send_samples();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            case (p / 3)
                0:       begin send_idle_pct = 13; recv_idle_pct = 76; end
                1:       begin send_idle_pct = 76; recv_idle_pct = 13; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            case (p)
                1:       begin b = 0;    w = 1023; t = 512;  end
                2:       begin b = 1023; w = 0;    t = 1023; end
                3:       begin b = 10;   w = 38;   t = 25;   end
                5:       begin b = 1023; w = 1023; t = 1023; end
                6:       begin
                    // Black above white: comparisons still apply as written
                    b = $urandom_range(1023, 500);
                    w = $urandom_range(400, 0);
                    t = $urandom_range(1023, 0);
                end
                7:       begin b = 0;    w = 0;    t = 0;    end
                default: begin
                    b = $urandom_range(300, 0);
                    w = b + $urandom_range(400, 2);
                    t = $urandom_range(w - 1, b + 1);
                end
            endcase
            apply_levels(b, w, t);
            while (stim_q.size() < ITEMS_PER_PHASE) begin
                if ($urandom_range(99, 0) < 15) begin
                    // Noise: arbitrary readings, breaking up any scan in progress
                    repeat ($urandom_range(6, 1))
                        stim_q.push_back(SAMPLE_W'($urandom_range(1023, 0)));
                end else begin
                    append_code();
                end
            end
            send_samples();
        end

        wait_drained();
        repeat (6) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
